// ----- rtl/rle_pkg.sv -----
package rle_pkg;

  localparam int unsigned ID_BITS   = 6;
  localparam int unsigned DIST_W    = 7;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = ID_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_INIT = 1'd1;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_IN     = 2'd1,
    MODE_OUT    = 2'd2,
    MODE_LEADER = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_IN     = 2'd0,
    KIND_OUT    = 2'd1,
    KIND_LEADER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_UNDECIDED = 2'd0,
    ST_DEFEATED  = 2'd1,
    ST_ELECTED   = 2'd2
  } status_e;

  typedef struct packed {
    mode_e               mode;
    logic                from_next;
    logic [ID_BITS-1:0]  origin_id;
    logic [DIST_W-1:0]   distance;
  } in_item_t;

  typedef struct packed {
    logic                to_next;
    kind_e               kind;
    logic [ID_BITS-1:0]  origin_id_out;
    logic [DIST_W-1:0]   distance_out;
    logic                last;
    status_e             election_status;
    logic [DIST_W-1:0]   ring_size;
  } out_item_t;

  // Up to two messages produced by one input transaction.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } step_res_t;

endpackage

// ----- rtl/rle_step.sv -----
module rle_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rle_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rle_pkg::CFG_DW-1:0]     cfg_wdata_i,
  input  rle_pkg::in_item_t              item_i,
  input  logic                           take_i,
  output rle_pkg::step_res_t             res_o
);
  import rle_pkg::*;

  logic [ID_BITS-1:0] node_id_q;
  logic               is_init_q;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [1:0]         reply_cnt_q, reply_cnt_d;
  logic               returned_q, returned_d;
  status_e            status_q, status_d;
  logic [DIST_W-1:0]  size_q, size_d;

  logic [DIST_W-1:0]  probe_dist;
  logic [2:0]         phase_m1;
  logic [8:0]         base;
  logic [9:0]         size_raw;
  logic [DIST_W-1:0]  size_clamp;

  assign probe_dist = (phase_q >= PHASE_W'(7)) ? '1 : DIST_W'(7'd1 << phase_q[2:0]);
  assign phase_m1   = phase_q[2:0] - 3'd1;

  // Distance covered by the previous phase; anything at or above 256 clamps the same way.
  always_comb begin
    if (phase_q == '0) begin
      base = '0;
    end else if (phase_q >= PHASE_W'(9)) begin
      base = 9'd256;
    end else begin
      base = 9'(9'd1 << phase_m1);
    end
  end

  assign size_raw = {1'b0, base} + 10'd1 - {3'b000, item_i.distance};

  always_comb begin
    if (size_raw[9]) begin
      size_clamp = '0;
    end else if (size_raw > 10'd127) begin
      size_clamp = '1;
    end else begin
      size_clamp = size_raw[DIST_W-1:0];
    end
  end

  always_comb begin
    logic launch;
    logic [1:0] rc_inc;
    launch      = 1'b0;
    rc_inc      = reply_cnt_q + 2'd1;
    phase_d     = phase_q;
    reply_cnt_d = reply_cnt_q;
    returned_d  = returned_q;
    status_d    = status_q;
    size_d      = size_q;
    res_o       = '0;

    case (item_i.mode)
      MODE_START: begin
        launch = is_init_q;
      end
      MODE_IN: begin
        if (item_i.origin_id == node_id_q) begin
          reply_cnt_d = rc_inc;
          launch      = (rc_inc == 2'd2);
        end else begin
          res_o.count               = 2'd1;
          res_o.first.to_next       = ~item_i.from_next;
          res_o.first.kind          = KIND_IN;
          res_o.first.origin_id_out = item_i.origin_id;
          res_o.first.distance_out  = '0;
        end
      end
      MODE_OUT: begin
        if (!is_init_q || item_i.origin_id > node_id_q) begin
          status_d                  = ST_DEFEATED;
          res_o.count               = 2'd1;
          res_o.first.origin_id_out = item_i.origin_id;
          if (item_i.distance > DIST_W'(1)) begin
            res_o.first.to_next      = ~item_i.from_next;
            res_o.first.kind         = KIND_OUT;
            res_o.first.distance_out = item_i.distance - DIST_W'(1);
          end else begin
            // Last hop: answer back toward the sender.
            res_o.first.to_next      = item_i.from_next;
            res_o.first.kind         = KIND_IN;
            res_o.first.distance_out = '0;
          end
        end else if (item_i.origin_id == node_id_q && !returned_q) begin
          returned_d                = 1'b1;
          status_d                  = ST_ELECTED;
          size_d                    = size_clamp;
          res_o.count               = 2'd1;
          res_o.first.to_next       = 1'b1;
          res_o.first.kind          = KIND_LEADER;
          res_o.first.origin_id_out = node_id_q;
          res_o.first.distance_out  = size_clamp;
        end
      end
      MODE_LEADER: begin
        if (item_i.origin_id != node_id_q) begin
          size_d                    = item_i.distance;
          res_o.count               = 2'd1;
          res_o.first.to_next       = 1'b1;
          res_o.first.kind          = KIND_LEADER;
          res_o.first.origin_id_out = item_i.origin_id;
          res_o.first.distance_out  = item_i.distance;
        end
      end
      default: begin
      end
    endcase

    if (launch) begin
      reply_cnt_d                = '0;
      returned_d                 = 1'b0;
      if (phase_q != '1) begin
        phase_d = phase_q + PHASE_W'(1);
      end
      res_o.count                = 2'd2;
      res_o.first.to_next        = 1'b0;
      res_o.first.kind           = KIND_OUT;
      res_o.first.origin_id_out  = node_id_q;
      res_o.first.distance_out   = probe_dist;
      res_o.second.to_next       = 1'b1;
      res_o.second.kind          = KIND_OUT;
      res_o.second.origin_id_out = node_id_q;
      res_o.second.distance_out  = probe_dist;
    end

    res_o.first.last             = (res_o.count == 2'd1);
    res_o.first.election_status  = status_d;
    res_o.first.ring_size        = size_d;
    res_o.second.last            = 1'b1;
    res_o.second.election_status = status_d;
    res_o.second.ring_size       = size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= '0;
      is_init_q   <= 1'b0;
      phase_q     <= '0;
      reply_cnt_q <= '0;
      returned_q  <= 1'b0;
      status_q    <= ST_UNDECIDED;
      size_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_ID: node_id_q <= cfg_wdata_i[ID_BITS-1:0];
          CFG_IS_INIT: is_init_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (take_i) begin
        phase_q     <= phase_d;
        reply_cnt_q <= reply_cnt_d;
        returned_q  <= returned_d;
        status_q    <= status_d;
        size_q      <= size_d;
      end
    end
  end

endmodule

// ----- rtl/rle_obuf.sv -----
module rle_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  rle_pkg::step_res_t  res_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rle_pkg::out_item_t  out_data_o
);
  import rle_pkg::*;

  logic [1:0] cnt_q;
  out_item_t  slot0_q, slot1_q;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= res_i.first;
      slot1_q <= res_i.second;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

// ----- rtl/ring_leader_election_node.sv -----
// An accepted input is held in the input register; its messages are then loaded into the
// result buffer. Throughput: one input per cycle while the output is not stalled and each
// input yields at most one message; a phase launch queues two messages for the single port.
// Reset clears the election state, the configuration registers (node id 0, not a candidate)
// and empties both the input register and the two-entry result buffer.
module ring_leader_election_node (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rle_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rle_pkg::CFG_DW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rle_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rle_pkg::out_item_t             out_data_o
);
  import rle_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_q;
  step_res_t res;
  logic      can_load;
  logic      advance;
  logic      in_take;

  // An item with no message leaves the input register regardless of the buffer.
  assign advance    = s1_valid_q && ((res.count == 2'd0) || can_load);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
  end

  rle_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (s1_q),
    .take_i      (advance),
    .res_o       (res)
  );

  rle_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (res.count != 2'd0)),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import rle_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;

  ring_leader_election_node u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Node state as this bench sees it.
  logic [ID_BITS-1:0] my_id = '0;
  logic               my_cand = 1'b0;
  logic [PHASE_W-1:0] cand_phase = '0;
  logic [1:0]         reply_cnt = '0;
  logic               probe_back = 1'b0;
  status_e            elect_st = ST_UNDECIDED;
  logic [DIST_W-1:0]  ring_len = '0;

  in_item_t  pending_msgs[$];
  out_item_t staged[$];
  out_item_t exp_msgs[$];

  int  n_queued = 0;
  int  n_acc = 0;
  int  n_out = 0;
  int  n_err = 0;
  int  n_launch = 0;
  int  n_elect = 0;
  int  n_settings = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  in_took = 1'b0;
  bit  calm = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_err(string msg);
    n_err++;
    $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want_v);
    if (got !== want_v) report_err($sformatf("%s: got %0d, expected %0d", name, got, want_v));
  endtask

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic out_item_t mk_msg(logic to_n, kind_e k, logic [ID_BITS-1:0] o,
                                       logic [DIST_W-1:0] d);
    out_item_t m;
    m = '0;
    m.to_next = to_n;
    m.kind = k;
    m.origin_id_out = o;
    m.distance_out = d;
    return m;
  endfunction

  // Probes of 2^phase hops (capped at 127) go out to the previous neighbor first, then the next one.
  function automatic void launch_probes();
    logic [DIST_W-1:0] d;
    d = (cand_phase >= 7) ? DIST_W'(127) : DIST_W'(1 << cand_phase);
    reply_cnt = '0;
    probe_back = 1'b0;
    staged.push_back(mk_msg(1'b0, KIND_OUT, my_id, d));
    staged.push_back(mk_msg(1'b1, KIND_OUT, my_id, d));
    if (cand_phase != '1) cand_phase++;
    n_launch++;
  endfunction

  function automatic void predict_messages(in_item_t it);
    int base;
    int len;
    case (it.mode)
      MODE_START: begin
        if (my_cand) launch_probes();
      end
      MODE_IN: begin
        // Replies to our own probes are counted even when not a candidate.
        if (it.origin_id == my_id) begin
          reply_cnt = reply_cnt + 2'd1;
          if (reply_cnt == 2'd2) launch_probes();
        end else begin
          staged.push_back(mk_msg(!it.from_next, KIND_IN, it.origin_id, '0));
        end
      end
      MODE_OUT: begin
        if (!my_cand || it.origin_id > my_id) begin
          elect_st = ST_DEFEATED;
          if (it.distance > 1)
            staged.push_back(mk_msg(!it.from_next, KIND_OUT, it.origin_id, it.distance - 1'b1));
          else
            staged.push_back(mk_msg(it.from_next, KIND_IN, it.origin_id, '0));
        end else if (it.origin_id == my_id && !probe_back) begin
          base = (cand_phase == 0) ? 0 : (1 << (cand_phase - 1));
          len = base - int'(it.distance) + 1;
          if (len < 0) len = 0;
          if (len > 127) len = 127;
          probe_back = 1'b1;
          elect_st = ST_ELECTED;
          ring_len = DIST_W'(len);
          n_elect++;
          staged.push_back(mk_msg(1'b1, KIND_LEADER, my_id, ring_len));
        end
      end
      default: begin
        if (it.origin_id != my_id) begin
          ring_len = it.distance;
          staged.push_back(mk_msg(1'b1, KIND_LEADER, it.origin_id, it.distance));
        end
      end
    endcase
    // Status and ring size are reported as they stand after the whole update.
    foreach (staged[k]) begin
      staged[k].last = (k == staged.size() - 1);
      staged[k].election_status = elect_st;
      staged[k].ring_size = ring_len;
      exp_msgs.push_back(staged[k]);
    end
    staged.delete();
  endfunction

  // Monitor: checks output transactions, then feeds accepted inputs to the predictor.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
      end else begin
        if (out_valid && !out_stall) begin
          n_out++;
          if (exp_msgs.size() == 0) begin
            report_err("output transaction with no message expected");
          end else begin
            want = exp_msgs.pop_front();
            check_field("to_next", 8'(out_data.to_next), 8'(want.to_next));
            check_field("kind", 8'(out_data.kind), 8'(want.kind));
            check_field("origin_id_out", 8'(out_data.origin_id_out), 8'(want.origin_id_out));
            check_field("distance_out", 8'(out_data.distance_out), 8'(want.distance_out));
            check_field("last", 8'(out_data.last), 8'(want.last));
            check_field("election_status", 8'(out_data.election_status),
                        8'(want.election_status));
            check_field("ring_size", 8'(out_data.ring_size), 8'(want.ring_size));
          end
        end
        in_took = in_valid && !in_stall;
        if (in_took) begin
          n_acc++;
          predict_messages(in_data);
        end
      end
    end
  end

  // Driver: holds a transaction until it is taken, then waits out a random gap.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_msgs.size() > 0) begin
        in_data <= pending_msgs.pop_front();
        in_valid <= 1'b1;
        gap_left <= $urandom_range(0, 1) ? 0 : next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 99) < 30) stall_left <= next_gap();
    end
  end

  task automatic queue_msg(mode_e m, logic f, logic [ID_BITS-1:0] o, logic [DIST_W-1:0] d);
    in_item_t it;
    it.mode = m;
    it.from_next = f;
    it.origin_id = o;
    it.distance = d;
    pending_msgs.push_back(it);
    n_queued++;
  endtask

  // Waits until every queued transaction is taken and every message has come out.
  task automatic drain();
    do @(negedge clk); while (n_acc != n_queued || exp_msgs.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_regs(logic [ID_BITS-1:0] id, logic cand);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_NODE_ID;
    cfg_wdata <= id;
    @(negedge clk);
    cfg_idx <= CFG_IS_INIT;
    cfg_wdata <= CFG_DW'(cand);
    @(negedge clk);
    cfg_we <= 1'b0;
    my_id = id;
    my_cand = cand;
    n_settings++;
  endtask

  task automatic add_round();
    int r;
    int hops;
    logic [ID_BITS-1:0] o;
    logic [DIST_W-1:0] d;
    logic f;
    r = $urandom_range(0, 99);
    f = 1'($urandom_range(0, 1));
    if (r < 35) begin
      // A candidate's own round: start, reply pairs, maybe its returning probe and leader message.
      queue_msg(MODE_START, f, ID_BITS'($urandom), DIST_W'($urandom));
      repeat ($urandom_range(0, 3)) begin
        queue_msg(MODE_IN, f, my_id, DIST_W'($urandom));
        queue_msg(MODE_IN, !f, my_id, DIST_W'($urandom));
      end
      if ($urandom_range(0, 1))
        queue_msg(MODE_OUT, 1'($urandom), my_id, DIST_W'($urandom_range(0, 127)));
      if ($urandom_range(0, 3) == 0)
        queue_msg(MODE_LEADER, 1'($urandom), my_id, DIST_W'($urandom));
    end else if (r < 65) begin
      // A foreign probe passing through on successive hops, then its reply.
      o = ID_BITS'($urandom);
      d = ($urandom_range(0, 3) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(0, 6));
      hops = $urandom_range(1, 4);
      for (int h = 0; h < hops; h++) begin
        queue_msg(MODE_OUT, f, o, d);
        if (d > 0) d--;
      end
      queue_msg(MODE_IN, !f, o, '0);
    end else if (r < 80) begin
      queue_msg(MODE_LEADER, f, ID_BITS'($urandom), DIST_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) queue_msg(mode_e'($urandom_range(0, 3)), 1'($urandom),
                                              ID_BITS'($urandom), DIST_W'($urandom));
    end
  endtask

  task automatic run_setting(logic [ID_BITS-1:0] id, logic cand, int count, bit quiet);
    int start;
    bit paused;
    start = n_queued;
    paused = 1'b0;
    drain();
    write_regs(id, cand);
    calm = quiet;
    while (n_queued - start < count) begin
      if (!paused && n_queued - start >= count / 2) begin
        drain();
        paused = 1'b1;
      end
      add_round();
    end
  endtask

  initial begin : stimulus
    logic [ID_BITS-1:0] node;
    logic cand;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_regs(6'd63, 1'b1);
    // Our own probe arrives before any phase was launched, so the size clamps at zero.
    queue_msg(MODE_OUT, 1'b0, 6'd63, 7'd5);
    queue_msg(MODE_START, 1'b0, 6'd0, 7'd0);
    queue_msg(MODE_START, 1'b1, 6'd63, 7'd127);
    queue_msg(MODE_IN, 1'b0, 6'd63, 7'd0);
    queue_msg(MODE_IN, 1'b1, 6'd63, 7'd0);
    queue_msg(MODE_IN, 1'b1, 6'd0, 7'd3);
    queue_msg(MODE_IN, 1'b0, 6'd21, 7'd0);
    queue_msg(MODE_OUT, 1'b0, 6'd10, 7'd3);
    queue_msg(MODE_OUT, 1'b1, 6'd63, 7'd3);
    queue_msg(MODE_OUT, 1'b0, 6'd63, 7'd1);
    queue_msg(MODE_LEADER, 1'b0, 6'd63, 7'd9);
    queue_msg(MODE_LEADER, 1'b1, 6'd0, 7'd127);
    drain();

    write_regs(6'd20, 1'b1);
    queue_msg(MODE_OUT, 1'b0, 6'd63, 7'd0);
    queue_msg(MODE_OUT, 1'b1, 6'd63, 7'd1);
    queue_msg(MODE_OUT, 1'b0, 6'd21, 7'd127);
    queue_msg(MODE_OUT, 1'b1, 6'd21, 7'd2);
    queue_msg(MODE_IN, 1'b0, 6'd20, 7'd0);
    queue_msg(MODE_IN, 1'b1, 6'd20, 7'd0);
    queue_msg(MODE_IN, 1'b0, 6'd20, 7'd0);
    queue_msg(MODE_IN, 1'b1, 6'd20, 7'd0);
    queue_msg(MODE_IN, 1'b0, 6'd20, 7'd0);
    queue_msg(MODE_LEADER, 1'b0, 6'd5, 7'd0);

    for (int s = 0; s < 8; s++) begin
      node = (s < 4) ? ((s % 2) ? 6'd63 : 6'd0) : ID_BITS'($urandom_range(1, 62));
      cand = (s < 4) ? (s == 1 || s == 2) : (s != 6);
      run_setting(node, cand, 160, s == 2 || s == 5);
    end

    drain();
    repeat (12) @(negedge clk);
    if (exp_msgs.size() != 0)
      report_err($sformatf("%0d messages never came out", exp_msgs.size()));
    $display("Covered %0d input and %0d output transactions across %0d register settings.",
             n_acc, n_out, n_settings);
    $display("Launched %0d probe phases and won %0d elections, ending in phase %0d.",
             n_launch, n_elect, cand_phase);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
